[rtl/core/tcce_pkg.sv]
// Shared types, constants and helpers for the text console character engine.
// Used by every module under rtl/core except tcce_ram; depends on nothing else.

package tcce_pkg;

  // Screen geometry and store sizing
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 32;
  localparam int TAB_STOPS  = 32;
  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int PTR_W      = ADDR_W + 1;

  // Field widths
  localparam int COL_W      = 6;
  localparam int ROW_W      = 5;
  localparam int CCOUNT_W   = COL_W + 1;
  localparam int RCOUNT_W   = ROW_W + 1;
  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int OP_W       = 2;
  localparam int CFGC_W     = 7;
  localparam int CFGR_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TDATA_IN_W  = 32;
  localparam int TDATA_OUT_W = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // Character codes with special handling
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR = 2'd2;
  localparam logic [CFGC_W-1:0]    COLS_RESET = 7'd56;
  localparam logic [CFGR_W-1:0]    ROWS_RESET = 6'd29;

  // Tab stop table: evenly spaced low stops, the rest at one high stop
  localparam int TAB_LOW_COUNT = 14;
  localparam int TAB_SPACING   = 4;
  localparam int TAB_HIGH_STOP = 55;

  function automatic logic [COL_W-1:0] tab_stop(input int unsigned n);
    logic [COL_W-1:0] v;
    if (n < TAB_LOW_COUNT) begin
      v = COL_W'(n * TAB_SPACING);
    end else begin
      v = COL_W'(TAB_HIGH_STOP);
    end
    return v;
  endfunction

  // Input word: op in the lowest bits, cell index in the highest
  typedef struct packed {
    logic [ADDR_W-1:0] cell_index;
    logic [COL_W-1:0]  target_col;
    logic [ROW_W-1:0]  target_row;
    logic [CHAR_W-1:0] char_code;
    logic [OP_W-1:0]   operation;
  } in_item_t;

  // Output word: cell data in the lowest bits, zero padding on top
  typedef struct packed {
    logic [TDATA_OUT_W-CELL_W-ROW_W-COL_W-1:0] pad;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SAT,
    ST_MUL,
    ST_EXEC,
    ST_RD,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic sat;
    logic mul;
    logic exec;
    logic rd_capture;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
    logic out_load;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rd;
    logic walk;
    logic in_copy;
    logic in_fill;
    logic out_busy;
  } dp_stat_t;

endpackage

[rtl/core/tcce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the screen cell store.

module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tcce_ctrl.sv]
// Sequencing state machine for the text console engine.
// Depends on tcce_pkg for the state type and the command and status structs.

module tcce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  tcce_pkg::dp_stat_t  stat,
  output tcce_pkg::ctrl_cmd_t cmd
);

  tcce_pkg::state_t state;
  tcce_pkg::state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcce_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcce_pkg::ST_CLEAR: begin
        if (!stat.in_fill) state_next = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tcce_pkg::ST_SAT;
      end
      tcce_pkg::ST_SAT:  state_next = tcce_pkg::ST_MUL;
      tcce_pkg::ST_MUL:  state_next = tcce_pkg::ST_EXEC;
      tcce_pkg::ST_EXEC: begin
        priority if (stat.rd) begin
          state_next = tcce_pkg::ST_RD;
        end else if (stat.walk) begin
          state_next = tcce_pkg::ST_COPY_RD;
        end else begin
          state_next = tcce_pkg::ST_DONE;
        end
      end
      tcce_pkg::ST_RD: state_next = tcce_pkg::ST_DONE;
      tcce_pkg::ST_COPY_RD: begin
        priority if (stat.in_copy) begin
          state_next = tcce_pkg::ST_COPY_WR;
        end else if (stat.in_fill) begin
          state_next = tcce_pkg::ST_FILL;
        end else begin
          state_next = tcce_pkg::ST_DONE;
        end
      end
      tcce_pkg::ST_COPY_WR: state_next = tcce_pkg::ST_COPY_RD;
      tcce_pkg::ST_FILL: begin
        if (!stat.in_fill) state_next = tcce_pkg::ST_DONE;
      end
      tcce_pkg::ST_DONE: begin
        if (!stat.out_busy) state_next = tcce_pkg::ST_IDLE;
      end
      default: state_next = tcce_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      tcce_pkg::ST_CLEAR:   cmd.fill_wr = stat.in_fill;
      tcce_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      tcce_pkg::ST_SAT:     cmd.sat = 1'b1;
      tcce_pkg::ST_MUL:     cmd.mul = 1'b1;
      tcce_pkg::ST_EXEC:    cmd.exec = 1'b1;
      tcce_pkg::ST_RD:      cmd.rd_capture = 1'b1;
      tcce_pkg::ST_COPY_RD: cmd.copy_rd = stat.in_copy;
      tcce_pkg::ST_COPY_WR: cmd.copy_wr = 1'b1;
      tcce_pkg::ST_FILL:    cmd.fill_wr = stat.in_fill;
      tcce_pkg::ST_DONE:    cmd.out_load = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/core/tcce_dpath.sv]
// Datapath of the text console engine: config registers, cursor, cell store
// and walk pointers. Depends on tcce_pkg and tcce_ram.

module tcce_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [tcce_pkg::TDATA_IN_W-1:0]       s_tdata,
  input  logic                                  m_tready,
  output logic                                  m_tvalid,
  output logic [tcce_pkg::TDATA_OUT_W-1:0]      m_tdata,
  input  tcce_pkg::ctrl_cmd_t                   cmd,
  output tcce_pkg::dp_stat_t                    stat
);

  localparam int AW = tcce_pkg::ADDR_W;
  localparam int PW = tcce_pkg::PTR_W;
  localparam int CW = tcce_pkg::COL_W;
  localparam int RW = tcce_pkg::ROW_W;
  localparam int CCW = tcce_pkg::CCOUNT_W;
  localparam int RCW = tcce_pkg::RCOUNT_W;

  // Configuration registers
  logic [tcce_pkg::CFGC_W-1:0] cfg_cols;
  logic [tcce_pkg::CFGR_W-1:0] cfg_rows;
  logic [tcce_pkg::CELL_W-1:0] attr;

  // Captured word
  tcce_pkg::in_item_t in_word;
  tcce_pkg::in_item_t item;

  // Cursor, products and walk pointers
  logic [RW-1:0]  cur_row;
  logic [CW-1:0]  cur_col;
  logic [AW-1:0]  base;
  logic [PW-1:0]  area;
  logic [PW-1:0]  ptr;
  logic [PW-1:0]  copy_end;
  logic [PW-1:0]  fill_end;
  logic [CCW-1:0] stride;
  logic           fill_zero;
  logic [tcce_pkg::CELL_W-1:0] res_cell;

  // Output register
  tcce_pkg::out_item_t out_word;
  logic                out_valid;

  // Effective geometry
  logic [CCW-1:0] cols;
  logic [RCW-1:0] rows;
  logic [CW-1:0]  cols_m1;
  logic [RW-1:0]  rows_m1;

  // Step decode
  logic           is_bs, is_ff, is_tab, plain;
  logic [CCW-1:0] col_inc;
  logic [RCW-1:0] row_inc;
  logic           wrap, bottom;
  logic [AW-1:0]  char_addr;
  logic           tab_found;
  logic [CW-1:0]  tab_hit;
  logic [CW-1:0]  tab_col;
  logic [RW-1:0]  set_row;
  logic [CW-1:0]  set_col;

  // Store ports
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [tcce_pkg::CELL_W-1:0] ram_wdata, ram_rdata, fill_cell;
  logic [PW-1:0]               src_ptr;

  assign in_word = tcce_pkg::in_item_t'(s_tdata);

  // Clamp geometry registers to the supported range
  always_comb begin
    if (cfg_cols == '0) begin
      cols = CCW'(1);
    end else if (cfg_cols > tcce_pkg::CFGC_W'(tcce_pkg::MAX_COLS)) begin
      cols = CCW'(tcce_pkg::MAX_COLS);
    end else begin
      cols = CCW'(cfg_cols);
    end
    if (cfg_rows == '0) begin
      rows = RCW'(1);
    end else if (cfg_rows > tcce_pkg::CFGR_W'(tcce_pkg::MAX_ROWS)) begin
      rows = RCW'(tcce_pkg::MAX_ROWS);
    end else begin
      rows = RCW'(cfg_rows);
    end
  end

  assign cols_m1 = CW'(cols - CCW'(1));
  assign rows_m1 = RW'(rows - RCW'(1));

  // Decode the put-character cases
  assign is_bs   = (item.char_code == tcce_pkg::CH_BS);
  assign is_ff   = (item.char_code == tcce_pkg::CH_FF);
  assign is_tab  = (item.char_code == tcce_pkg::CH_TAB);
  assign plain   = !is_bs && !is_ff && !is_tab;
  assign col_inc = CCW'(cur_col) + CCW'(1);
  assign row_inc = RCW'(cur_row) + RCW'(1);
  assign wrap    = (col_inc >= cols);
  assign bottom  = (row_inc >= rows);
  assign char_addr = base + AW'(cur_col);

  // First tab stop past the cursor, clamped to the last column; the cursor stays if there is none
  always_comb begin
    tab_found = 1'b0;
    tab_hit   = '0;
    for (int i = 0; i < tcce_pkg::TAB_STOPS; i++) begin
      if (!tab_found && (cur_col < tcce_pkg::tab_stop(i))) begin
        tab_found = 1'b1;
        tab_hit   = tcce_pkg::tab_stop(i);
      end
    end
    if (!tab_found) begin
      tab_col = cur_col;
    end else if (tab_hit > cols_m1) begin
      tab_col = cols_m1;
    end else begin
      tab_col = tab_hit;
    end
  end

  // Saturated set-cursor target
  assign set_row = (item.target_row > rows_m1) ? rows_m1 : item.target_row;
  assign set_col = (item.target_col > cols_m1) ? cols_m1 : item.target_col;

  // Status for the controller
  assign stat.rd      = (item.operation == tcce_pkg::OP_READ);
  assign stat.walk    = (item.operation == tcce_pkg::OP_PUT) &&
                        ((is_bs && (cur_col != '0)) || is_ff || (plain && wrap && bottom));
  assign stat.in_copy = (ptr < copy_end);
  assign stat.in_fill = (ptr < fill_end);
  assign stat.out_busy = out_valid && !m_tready;

  // Store port selection
  assign fill_cell = fill_zero ? '0 : (attr | tcce_pkg::CELL_W'(tcce_pkg::CH_SPACE));
  assign src_ptr   = ptr + PW'(stride);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = fill_cell;
    ram_re    = cmd.copy_rd;
    ram_raddr = src_ptr[AW-1:0];
    if (cmd.exec && (item.operation == tcce_pkg::OP_PUT) && plain) begin
      ram_we    = 1'b1;
      ram_waddr = char_addr;
      ram_wdata = attr | tcce_pkg::CELL_W'(item.char_code);
    end
    if (cmd.copy_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end
    if (cmd.fill_wr) begin
      ram_we = 1'b1;
    end
    if (cmd.exec && (item.operation == tcce_pkg::OP_READ)) begin
      ram_re    = 1'b1;
      ram_raddr = item.cell_index;
    end
  end

  tcce_ram #(
    .WIDTH (tcce_pkg::CELL_W),
    .DEPTH (tcce_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols <= tcce_pkg::COLS_RESET;
      cfg_rows <= tcce_pkg::ROWS_RESET;
      attr     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcce_pkg::CFG_COLS: cfg_cols <= cfg_data[tcce_pkg::CFGC_W-1:0];
        tcce_pkg::CFG_ROWS: cfg_rows <= cfg_data[tcce_pkg::CFGR_W-1:0];
        tcce_pkg::CFG_ATTR: attr     <= cfg_data[tcce_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input word and products of the cursor row and geometry
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item <= in_word;
    end
    if (cmd.mul) begin
      base <= AW'(AW'(cur_row) * AW'(cols));
      area <= PW'(PW'(rows) * PW'(cols));
    end
    if (cmd.load_in) begin
      res_cell <= '0;
    end else if (cmd.rd_capture) begin
      res_cell <= ram_rdata;
    end
  end

  // Cursor and walk pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      ptr       <= '0;
      copy_end  <= '0;
      fill_end  <= PW'(tcce_pkg::CELL_COUNT);
      stride    <= '0;
      fill_zero <= 1'b1;
    end else begin
      if (cmd.sat) begin
        if (cur_row > rows_m1) cur_row <= rows_m1;
        if (cur_col > cols_m1) cur_col <= cols_m1;
      end
      if (cmd.copy_wr || cmd.fill_wr) begin
        ptr <= ptr + PW'(1);
      end
      if (cmd.exec) begin
        unique case (item.operation)
          tcce_pkg::OP_PUT: begin
            priority if (is_bs) begin
              if (cur_col != '0) begin
                cur_col   <= cur_col - CW'(1);
                ptr       <= PW'(char_addr) - PW'(1);
                copy_end  <= PW'(base) + PW'(cols) - PW'(1);
                fill_end  <= PW'(base) + PW'(cols);
                stride    <= CCW'(1);
                fill_zero <= 1'b0;
              end
            end else if (is_ff) begin
              cur_row   <= '0;
              cur_col   <= '0;
              ptr       <= '0;
              copy_end  <= '0;
              fill_end  <= area;
              fill_zero <= 1'b0;
            end else if (is_tab) begin
              cur_col <= tab_col;
            end else begin
              if (!wrap) begin
                cur_col <= CW'(col_inc);
              end else begin
                cur_col <= '0;
                if (!bottom) begin
                  cur_row <= RW'(row_inc);
                end else begin
                  cur_row   <= rows_m1;
                  ptr       <= '0;
                  copy_end  <= area - PW'(cols);
                  fill_end  <= area;
                  stride    <= cols;
                  fill_zero <= 1'b0;
                end
              end
            end
          end
          tcce_pkg::OP_SET: begin
            cur_row <= set_row;
            cur_col <= set_col;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register: drop on take, load when the step is done
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.pad        <= '0;
      out_word.cursor_col <= cur_col;
      out_word.cursor_row <= cur_row;
      out_word.cell_data  <= res_cell;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;

endmodule

[rtl/core/text_console_character_engine_core.sv]
// Text console character engine: 64x32 store of 16-bit cells, cursor, tab stops.
// Each item steps through saturate, multiply and execute, plus a read-capture state for reads, then done.
// Backspace shifts the rest of the row left then fills its last cell, form feed fills the screen, and a
// scroll copies rows up then fills the last row, cell by cell; s_tready stays low until the item is through.
// Reset (rst, synchronous) clears the store in one pass with s_tready low.
// Depends on tcce_pkg, tcce_ctrl, tcce_dpath and tcce_ram.

module text_console_character_engine_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write port
  input  logic                                  cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Input words
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // operation[1:0], char_code[9:2], target_row[14:10], target_col[20:15],
  // cell_index[31:21]
  input  logic [tcce_pkg::TDATA_IN_W-1:0]       s_tdata,
  // Result words
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // cell_data[15:0], cursor_row[20:16], cursor_col[26:21], zero[31:27]
  output logic [tcce_pkg::TDATA_OUT_W-1:0]      m_tdata
);

  tcce_pkg::ctrl_cmd_t cmd;
  tcce_pkg::dp_stat_t  stat;

  // Sequencer
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Registers, cell store and output word
  tcce_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
